// ----- hdl/lsr_pkg.sv -----
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared types and constants for the SET/UA link setup requester.
// ----------------------------------------------------------------------------
package lsr_pkg;

  localparam logic [7:0] FlagByte        = 8'h7e;
  localparam logic [15:0] TimeoutReset   = 16'd3;
  localparam logic [3:0] MaxAttemptsReset = 4'd3;
  localparam logic [7:0] AddressReset    = 8'h03;
  localparam logic [7:0] SetCtrlReset    = 8'h03;
  localparam logic [7:0] UaCtrlReset     = 8'h07;
  localparam int unsigned FrameLen       = 5;
  localparam int unsigned BeatIdxW       = $clog2(FrameLen);
  localparam int unsigned JobDepth       = 2;
  localparam int unsigned CfgAddrW       = 5;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_BYTE  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } lsr_cmd_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_CONN = 2'd2,
    PH_FAIL = 2'd3
  } lsr_phase_e;

  typedef enum logic [2:0] {
    PS_START = 3'd0,
    PS_FLAG  = 3'd1,
    PS_ADDR  = 3'd2,
    PS_CTRL  = 3'd3,
    PS_BCC   = 3'd4,
    PS_STOP  = 3'd5
  } lsr_ps_e;

  typedef enum logic [2:0] {
    REG_TIMEOUT  = 3'd0,
    REG_MAX_ATT  = 3'd1,
    REG_ADDRESS  = 3'd2,
    REG_SET_CTRL = 3'd3,
    REG_UA_CTRL  = 3'd4
  } lsr_reg_e;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [3:0]  max_attempts;
    logic [7:0]  address_byte;
    logic [7:0]  set_control;
    logic [7:0]  ua_control;
  } lsr_cfg_t;

  typedef struct packed {
    logic       frame;
    lsr_phase_e status;
  } lsr_job_t;

endpackage

// ----- hdl/lsr_front.sv -----
// ----------------------------------------------------------------------------
// lsr_front
// Accepts command beats, runs the link phase, timer and UA recognizer, and
// posts one job per beat to the result queue.
// ----------------------------------------------------------------------------
module lsr_front import lsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  lsr_cfg_t cfg_i,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic [1:0] in_cmd_i,
  input  logic [7:0] in_byte_i,
  input  logic     job_full_i,
  output logic     job_push_o,
  output lsr_job_t job_o
);

  lsr_phase_e  phase_q, phase_d;
  lsr_ps_e     ps_q, ps_d, ps_rx;
  logic [15:0] ticks_q, ticks_d;
  logic [3:0]  att_q, att_d;
  logic [3:0]  limit;
  logic [7:0]  bcc;
  logic        accept;

  assign in_ready_o = !job_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign job_push_o = accept;
  assign limit      = (cfg_i.max_attempts == 4'd0) ? 4'd1 : cfg_i.max_attempts;
  assign bcc        = cfg_i.address_byte ^ cfg_i.ua_control;

  always_comb begin
    ps_rx = PS_START;
    unique case (ps_q)
      PS_START: ps_rx = (in_byte_i == FlagByte) ? PS_FLAG : PS_START;
      PS_FLAG: begin
        if (in_byte_i == cfg_i.address_byte) ps_rx = PS_ADDR;
        else ps_rx = (in_byte_i == FlagByte) ? PS_FLAG : PS_START;
      end
      PS_ADDR: begin
        if (in_byte_i == cfg_i.ua_control) ps_rx = PS_CTRL;
        else ps_rx = (in_byte_i == FlagByte) ? PS_FLAG : PS_START;
      end
      PS_CTRL: begin
        if (in_byte_i == bcc) ps_rx = PS_BCC;
        else ps_rx = (in_byte_i == FlagByte) ? PS_FLAG : PS_START;
      end
      PS_BCC:  ps_rx = (in_byte_i == FlagByte) ? PS_STOP : PS_START;
      PS_STOP: ps_rx = PS_STOP;
      default: ps_rx = PS_START;
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    ps_d      = ps_q;
    ticks_d   = ticks_q;
    att_d     = att_q;
    job_o.frame = 1'b0;
    if (accept) begin
      unique case (lsr_cmd_e'(in_cmd_i))
        CMD_START: begin
          att_d       = 4'd1;
          ticks_d     = cfg_i.timeout_ticks;
          ps_d        = PS_START;
          phase_d     = PH_WAIT;
          job_o.frame = 1'b1;
        end
        CMD_BYTE: begin
          if (phase_q == PH_WAIT) begin
            ps_d = ps_rx;
            if (ps_rx == PS_STOP) phase_d = PH_CONN;
          end
        end
        CMD_TICK: begin
          if (phase_q == PH_WAIT) begin
            if (ticks_q > 16'd1) begin
              ticks_d = ticks_q - 16'd1;
            end else if (att_q < limit) begin
              att_d       = att_q + 4'd1;
              ticks_d     = cfg_i.timeout_ticks;
              ps_d        = PS_START;
              job_o.frame = 1'b1;
            end else begin
              ticks_d = 16'd0;
              phase_d = PH_FAIL;
            end
          end
        end
        default: ;
      endcase
    end
    job_o.status = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      ps_q    <= PS_START;
      ticks_q <= 16'd0;
      att_q   <= 4'd0;
    end else begin
      phase_q <= phase_d;
      ps_q    <= ps_d;
      ticks_q <= ticks_d;
      att_q   <= att_d;
    end
  end

endmodule

// ----- hdl/lsr_queue.sv -----
// ----------------------------------------------------------------------------
// lsr_queue
// Short job queue between the command front and the beat generator.
// ----------------------------------------------------------------------------
module lsr_queue import lsr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lsr_job_t job_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output lsr_job_t job_o
);

  localparam int unsigned PtrW = $clog2(JobDepth);
  localparam int unsigned CntW = $clog2(JobDepth + 1);

  lsr_job_t            slot_q [JobDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(JobDepth));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(JobDepth - 1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(JobDepth - 1)) ? '0 : rd_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- hdl/lsr_back.sv -----
// ----------------------------------------------------------------------------
// lsr_back
// Turns queued jobs into result beats: five SET bytes or one status beat.
// ----------------------------------------------------------------------------
module lsr_back import lsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lsr_cfg_t    cfg_i,
  input  logic        job_valid_i,
  input  lsr_job_t    job_i,
  output logic        job_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        out_txv_o,
  output logic        out_last_o,
  output logic [1:0]  out_status_o
);

  logic                cur_valid_q, cur_valid_d;
  lsr_job_t            cur_q, cur_d;
  logic [BeatIdxW-1:0] idx_q, idx_d;
  logic                take, end_beat, load;

  assign take     = cur_valid_q && out_ready_i;
  assign end_beat = !cur_q.frame || (idx_q == BeatIdxW'(FrameLen - 1));
  assign load     = !cur_valid_q || (take && end_beat);
  assign job_pop_o = load && job_valid_i;

  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_d       = cur_q;
    idx_d       = idx_q;
    if (load) begin
      cur_valid_d = job_valid_i;
      cur_d       = job_i;
      idx_d       = '0;
    end else if (take) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  always_comb begin
    out_byte_o = 8'd0;
    if (cur_q.frame) begin
      case (idx_q)
        BeatIdxW'(1): out_byte_o = cfg_i.address_byte;
        BeatIdxW'(2): out_byte_o = cfg_i.set_control;
        BeatIdxW'(3): out_byte_o = cfg_i.address_byte ^ cfg_i.set_control;
        default:      out_byte_o = FlagByte;
      endcase
    end
  end

  assign out_valid_o  = cur_valid_q;
  assign out_txv_o    = cur_q.frame;
  assign out_last_o   = end_beat;
  assign out_status_o = cur_q.status;

endmodule

// ----- hdl/link_setup_set_ua_retry.sv -----
// ----------------------------------------------------------------------------
// link_setup_set_ua_retry
// Requester side of a SET/UA link setup with timeout and resend.
// ----------------------------------------------------------------------------
// Command beats enter on s_axis: tuser is the command (start, received byte,
// timer tick), tdata the received byte. Result beats leave on m_axis: tdata
// holds the byte to send and the link status, tuser marks a SET frame byte,
// tlast closes the results of one command.
// A start, or a timeout with attempts left, yields five beats (the SET
// frame); every other command yields a single status beat.
// The front handles one command per cycle while the queue has room; its
// first result beat passes the queue, then the back end's job register.
// With m_axis ready, single-beat commands sustain one per cycle; a frame
// holds it for five beats, one per cycle, by the back end's beat counter.
// A two-entry job queue separates the two: while m_axis stalls, s_axis keeps
// taking commands until the queue fills, then drops tready.
// Reset clears the phase to idle, the timer and attempt count to zero and
// the registers to their defaults. Registers are written over APB at 4*i.
// ----------------------------------------------------------------------------
module link_setup_set_ua_retry import lsr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // [7:0] rx_byte
  input  logic [1:0]          s_axis_tuser_i,  // [1:0] cmd
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [15:0]         m_axis_tdata_o,  // [7:0] tx_byte, [9:8] status
  output logic                m_axis_tuser_o,  // [0] tx_valid
  output logic                m_axis_tlast_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  lsr_cfg_t   cfg_q;
  lsr_job_t   push_job, head_job;
  logic       push, full, pop, head_valid;
  logic [7:0] tx_byte;
  logic [1:0] status;
  logic       wr_en;
  lsr_reg_e   reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = lsr_reg_e'(paddr[CfgAddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.timeout_ticks <= TimeoutReset;
      cfg_q.max_attempts  <= MaxAttemptsReset;
      cfg_q.address_byte  <= AddressReset;
      cfg_q.set_control   <= SetCtrlReset;
      cfg_q.ua_control    <= UaCtrlReset;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_TIMEOUT:  cfg_q.timeout_ticks <= pwdata[15:0];
        REG_MAX_ATT:  cfg_q.max_attempts  <= pwdata[3:0];
        REG_ADDRESS:  cfg_q.address_byte  <= pwdata[7:0];
        REG_SET_CTRL: cfg_q.set_control   <= pwdata[7:0];
        REG_UA_CTRL:  cfg_q.ua_control    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_TIMEOUT:  prdata = {16'd0, cfg_q.timeout_ticks};
      REG_MAX_ATT:  prdata = {28'd0, cfg_q.max_attempts};
      REG_ADDRESS:  prdata = {24'd0, cfg_q.address_byte};
      REG_SET_CTRL: prdata = {24'd0, cfg_q.set_control};
      REG_UA_CTRL:  prdata = {24'd0, cfg_q.ua_control};
      default:      prdata = 32'd0;
    endcase
  end

  lsr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_cmd_i   (s_axis_tuser_i),
    .in_byte_i  (s_axis_tdata_i),
    .job_full_i (full),
    .job_push_o (push),
    .job_o      (push_job)
  );

  lsr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .job_o   (head_job)
  );

  lsr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .job_valid_i  (head_valid),
    .job_i        (head_job),
    .job_pop_o    (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_byte_o   (tx_byte),
    .out_txv_o    (m_axis_tuser_o),
    .out_last_o   (m_axis_tlast_o),
    .out_status_o (status)
  );

  assign m_axis_tdata_o = {6'd0, status, tx_byte};

endmodule

// ----- hdl/lsr_chk.sv -----
// ----------------------------------------------------------------------------
// lsr_chk
// Port-level checks for the link setup requester, bound to the top level.
// ----------------------------------------------------------------------------
module lsr_chk import lsr_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [15:0]         m_axis_tdata_o,
  input logic                m_axis_tuser_o,
  input logic                m_axis_tlast_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  a_mid_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tlast_o |-> m_axis_tuser_o)
    else $error("non-final beat outside a frame");

  a_idle_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[7:0] == 8'd0)
    else $error("status beat carries a byte");

  a_frame_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o[9:8] == PH_WAIT)
    else $error("frame beat without waiting status");

endmodule

bind link_setup_set_ua_retry lsr_chk u_chk (.*);
